FILE: hw/rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants of the order book matcher
// Operation and status codes, slot record layout and write-port controls.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int DEF_ORDER_SLOTS = 32;
  localparam int ID_W   = 64;
  localparam int PX_W   = 32;
  localparam int QTY_W  = 32;
  localparam int ARR_W  = 48;
  localparam int RC_W   = 6;

  typedef enum logic [1:0] {
    K_ADD    = 2'd0,
    K_CANCEL = 2'd1,
    K_UPDATE = 2'd2,
    K_DISC   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic SIDE_BUY = 1'b0;
  localparam logic RK_TRADE = 1'b0;
  localparam logic RK_STAT  = 1'b1;

  typedef struct packed {
    logic                    side;
    logic signed [PX_W-1:0]  price;
    logic [QTY_W-1:0]        size;
    logic [ID_W-1:0]         oid;
    logic [ID_W-1:0]         cid;
    logic [ARR_W-1:0]        arr;
  } slot_t;

  // write enables: whole record, size only, arrival stamp only
  typedef struct packed {
    logic all;
    logic size;
    logic arr;
  } wr_t;

endpackage

FILE: hw/rtl/lobm_slots.sv
// ----------------------------------------------------------------------------
// lobm_slots: resting-order slot storage
// One write port with per-field enables, one read port with registered data.
// ----------------------------------------------------------------------------
module lobm_slots #(
  parameter int ORDER_SLOTS = lobm_pkg::DEF_ORDER_SLOTS,
  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1
) (
  input  logic            clk_i,
  input  lobm_pkg::wr_t   wr_i,
  input  logic [IW-1:0]   wr_addr_i,
  input  lobm_pkg::slot_t wr_data_i,
  input  logic [IW-1:0]   rd_addr_i,
  output lobm_pkg::slot_t rd_data_o
);
  import lobm_pkg::*;

  slot_t mem_q [ORDER_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.all) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end else begin
      if (wr_i.size) mem_q[wr_addr_i].size <= wr_data_i.size;
      if (wr_i.arr)  mem_q[wr_addr_i].arr  <= wr_data_i.arr;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

FILE: hw/rtl/limit_order_book_matcher_core.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core: price-time priority limit order book
// Sequencer driving a slot scan unit over the resting-order storage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation: add,
//   cancel, update size or disconnect client. Output channel
//   (out_valid_o / out_stall_i) returns zero or more trade records followed
//   by one status record with last_o set.
//   Every operation runs as a series of passes over the slot table. A pass
//   reads one slot per cycle, between a setup step and the pipeline drain
//   and decision steps; it finds the id match, the first free slot, the
//   best bid and the best ask at once.
//   Cancel and update take two passes (one if the id is not found),
//   disconnect two, a rejected add one, and an add with k fills about
//   k + 1 passes (+1 if it rests).
//   The block takes one operation at a time: in_stall_o stays high from the
//   transfer of an operation until its status record has been transferred.
//   A stalled receiver simply holds the block in its output state with the
//   record steady on the ports.
//   Reset empties the book (all slot valid flags clear) and zeroes the
//   arrival counter; slot payload storage is not cleared.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core #(
  parameter int ORDER_SLOTS = lobm_pkg::DEF_ORDER_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [lobm_pkg::ID_W-1:0]     order_id_i,
  input  logic [lobm_pkg::ID_W-1:0]     client_id_i,
  input  logic                          side_i,
  input  logic                          order_type_i,
  input  logic signed [lobm_pkg::PX_W-1:0] limit_price_i,
  input  logic [lobm_pkg::QTY_W-1:0]    quantity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [lobm_pkg::ID_W-1:0]     buy_order_id_o,
  output logic [lobm_pkg::ID_W-1:0]     sell_order_id_o,
  output logic signed [lobm_pkg::PX_W-1:0] trade_price_o,
  output logic [lobm_pkg::QTY_W-1:0]    trade_size_o,
  output logic [1:0]                    status_o,
  output logic [lobm_pkg::RC_W-1:0]     removed_count_o,
  output logic signed [lobm_pkg::PX_W-1:0] best_bid_o,
  output logic                          best_bid_valid_o,
  output logic signed [lobm_pkg::PX_W-1:0] best_ask_o,
  output logic                          best_ask_valid_o,
  output logic                          last_o
);
  import lobm_pkg::*;

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_PRE, S_SCAN, S_DECIDE, S_FILL, S_OUT} state_e;
  // pass purpose: first look at the book, match round, status only
  typedef enum logic [1:0] {M_FIRST, M_MATCH, M_STAT} mode_e;

  state_e state_q;
  mode_e  mode_q;
  logic   done_q;

  // captured operation
  kind_e                kind_q;
  logic [ID_W-1:0]      oid_q, cid_q;
  logic                 side_q, mkt_q;
  logic signed [PX_W-1:0] px_q;
  logic [QTY_W-1:0]     qty_q, rem_q;
  status_e              st_q;
  logic [RC_W-1:0]      cnt_q;

  // book state
  logic [ORDER_SLOTS-1:0] valid_q;
  logic [ARR_W-1:0]       arr_cnt_q;

  // scan pointer and compare stage
  logic [CW-1:0] idx_q;
  logic          cvld_q;
  logic [IW-1:0] cidx_q;
  slot_t         rd_data;

  // scan results
  logic            hit_q, free_q;
  logic [IW-1:0]   hit_idx_q, free_idx_q;
  logic [QTY_W-1:0] hit_size_q;
  logic            bb_v_q, ba_v_q;
  logic signed [PX_W-1:0] bb_p_q, ba_p_q;
  logic [ARR_W-1:0] bb_a_q, ba_a_q;
  logic [IW-1:0]   t_idx_q;
  logic [QTY_W-1:0] t_size_q;
  logic [ID_W-1:0] t_oid_q, t_cid_q;

  // storage write port
  wr_t           wr_q;
  logic [IW-1:0] wr_addr_q;
  slot_t         wr_data_q;

  lobm_slots #(.ORDER_SLOTS(ORDER_SLOTS)) u_slots (
    .clk_i     (clk_i),
    .wr_i      (wr_q),
    .wr_addr_i (wr_addr_q),
    .wr_data_i (wr_data_q),
    .rd_addr_i (idx_q[IW-1:0]),
    .rd_data_o (rd_data)
  );

  // compare unit on the slot under test
  logic c_v, bid_better, ask_better, c_hit, c_disc;
  always_comb begin
    c_v        = cvld_q && valid_q[cidx_q];
    bid_better = c_v && (rd_data.side == SIDE_BUY) &&
                 (!bb_v_q || (rd_data.price > bb_p_q) ||
                  ((rd_data.price == bb_p_q) && (rd_data.arr < bb_a_q)));
    ask_better = c_v && (rd_data.side != SIDE_BUY) &&
                 (!ba_v_q || (rd_data.price < ba_p_q) ||
                  ((rd_data.price == ba_p_q) && (rd_data.arr < ba_a_q)));
    c_hit      = c_v && (rd_data.oid == oid_q);
    c_disc     = c_v && (mode_q == M_FIRST) && (kind_q == K_DISC) &&
                 (rd_data.cid == cid_q);
  end

  // match decision after a pass
  logic do_match, crosses, other_v;
  logic [QTY_W-1:0] amt, rest_size, rem_next;
  always_comb begin
    do_match  = (mode_q == M_MATCH) ||
                ((mode_q == M_FIRST) && (kind_q == K_ADD) &&
                 (qty_q != '0) && !hit_q);
    other_v   = (side_q == SIDE_BUY) ? ba_v_q : bb_v_q;
    crosses   = other_v && (mkt_q ||
                ((side_q == SIDE_BUY) ? (px_q >= ba_p_q) : (px_q <= bb_p_q)));
    amt       = (rem_q < t_size_q) ? rem_q : t_size_q;
    rest_size = t_size_q - amt;
    rem_next  = rem_q - amt;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_FIRST;
      done_q      <= 1'b0;
      valid_q     <= '0;
      arr_cnt_q   <= '0;
      idx_q       <= '0;
      cvld_q      <= 1'b0;
      wr_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          wr_q <= '0;
          if (in_valid_i) begin
            kind_q  <= kind_e'(kind_i);
            oid_q   <= order_id_i;
            cid_q   <= client_id_i;
            side_q  <= side_i;
            mkt_q   <= order_type_i;
            px_q    <= limit_price_i;
            qty_q   <= quantity_i;
            rem_q   <= quantity_i;
            cnt_q   <= '0;
            st_q    <= ST_DONE;
            mode_q  <= M_FIRST;
            state_q <= S_PRE;
          end
        end
        S_PRE: begin
          wr_q    <= '0;
          idx_q   <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          wr_q <= '0;
          if (idx_q == '0) begin
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            bb_v_q <= 1'b0;
            ba_v_q <= 1'b0;
          end
          cvld_q <= (idx_q != CW'(ORDER_SLOTS));
          cidx_q <= idx_q[IW-1:0];
          if (idx_q != CW'(ORDER_SLOTS)) idx_q <= idx_q + 1'b1;
          if (cvld_q) begin
            if (!hit_q && c_hit) begin
              hit_q      <= 1'b1;
              hit_idx_q  <= cidx_q;
              hit_size_q <= rd_data.size;
            end
            if (!free_q && !valid_q[cidx_q]) begin
              free_q     <= 1'b1;
              free_idx_q <= cidx_q;
            end
            if (bid_better) begin
              bb_v_q <= 1'b1;
              bb_p_q <= rd_data.price;
              bb_a_q <= rd_data.arr;
            end
            if (ask_better) begin
              ba_v_q <= 1'b1;
              ba_p_q <= rd_data.price;
              ba_a_q <= rd_data.arr;
            end
            if ((side_q == SIDE_BUY) ? ask_better : bid_better) begin
              t_idx_q  <= cidx_q;
              t_size_q <= rd_data.size;
              t_oid_q  <= rd_data.oid;
              t_cid_q  <= rd_data.cid;
            end
            if (c_disc) begin
              valid_q[cidx_q] <= 1'b0;
              cnt_q           <= cnt_q + 1'b1;
            end
          end
          if ((idx_q == CW'(ORDER_SLOTS)) && !cvld_q) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          done_q <= 1'b1;
          priority if (mode_q == M_STAT) begin
            wr_q    <= '0;
            state_q <= S_OUT;
          end else if (do_match) begin
            priority if (crosses) begin
              wr_q    <= '0;
              state_q <= S_FILL;
            end else if (mkt_q) begin
              wr_q    <= '0;
              state_q <= S_OUT;
            end else if (free_q) begin
              valid_q[free_idx_q] <= 1'b1;
              wr_q            <= '{all: 1'b1, size: 1'b0, arr: 1'b0};
              wr_addr_q       <= free_idx_q;
              wr_data_q.side  <= side_q;
              wr_data_q.price <= px_q;
              wr_data_q.size  <= rem_q;
              wr_data_q.oid   <= oid_q;
              wr_data_q.cid   <= cid_q;
              wr_data_q.arr   <= arr_cnt_q;
              arr_cnt_q       <= arr_cnt_q + 1'b1;
              mode_q          <= M_STAT;
              state_q         <= S_PRE;
            end else begin
              wr_q    <= '0;
              st_q    <= ST_FULL;
              state_q <= S_OUT;
            end
          end else if (kind_q == K_ADD) begin
            wr_q    <= '0;
            st_q    <= ST_REJECT;
            state_q <= S_OUT;
          end else if (kind_q == K_DISC) begin
            wr_q    <= '0;
            mode_q  <= M_STAT;
            state_q <= S_PRE;
          end else if (!hit_q) begin
            wr_q    <= '0;
            st_q    <= ST_NOTFOUND;
            state_q <= S_OUT;
          end else begin
            wr_addr_q      <= hit_idx_q;
            wr_data_q.size <= qty_q;
            wr_data_q.arr  <= arr_cnt_q;
            priority if ((kind_q == K_CANCEL) || (qty_q == '0)) begin
              wr_q               <= '0;
              valid_q[hit_idx_q] <= 1'b0;
            end else if (qty_q <= hit_size_q) begin
              wr_q <= '{all: 1'b0, size: 1'b1, arr: 1'b0};
            end else begin
              wr_q      <= '{all: 1'b0, size: 1'b1, arr: 1'b1};
              arr_cnt_q <= arr_cnt_q + 1'b1;
            end
            mode_q  <= M_STAT;
            state_q <= S_PRE;
          end
          // status record, used when leaving for the output state
          result_kind_o    <= RK_STAT;
          buy_order_id_o   <= '0;
          sell_order_id_o  <= '0;
          trade_price_o    <= '0;
          trade_size_o     <= '0;
          status_o         <= (mode_q == M_STAT) ? st_q :
                              (do_match && !crosses && !mkt_q) ? ST_FULL :
                              do_match ? ST_DONE :
                              (kind_q == K_ADD) ? ST_REJECT : ST_NOTFOUND;
          removed_count_o  <= (kind_q == K_DISC) ? cnt_q : '0;
          best_bid_o       <= bb_v_q ? bb_p_q : '0;
          best_bid_valid_o <= bb_v_q;
          best_ask_o       <= ba_v_q ? ba_p_q : '0;
          best_ask_valid_o <= ba_v_q;
          last_o           <= 1'b1;
          if ((mode_q == M_STAT) || (do_match && !crosses && (mkt_q || !free_q)) ||
              (!do_match && (kind_q == K_ADD)) ||
              (!do_match && (kind_q != K_DISC) && !hit_q)) begin
            out_valid_o <= 1'b1;
          end
        end
        S_FILL: begin
          wr_q           <= '{all: 1'b0, size: 1'b1, arr: 1'b0};
          wr_addr_q      <= t_idx_q;
          wr_data_q.size <= rest_size;
          if (rest_size == '0) valid_q[t_idx_q] <= 1'b0;
          rem_q  <= rem_next;
          mode_q <= (rem_next == '0) ? M_STAT : M_MATCH;
          if (t_cid_q != cid_q) begin
            done_q           <= 1'b0;
            out_valid_o      <= 1'b1;
            result_kind_o    <= RK_TRADE;
            buy_order_id_o   <= (side_q == SIDE_BUY) ? oid_q : t_oid_q;
            sell_order_id_o  <= (side_q == SIDE_BUY) ? t_oid_q : oid_q;
            trade_price_o    <= (side_q == SIDE_BUY) ? ba_p_q : bb_p_q;
            trade_size_o     <= amt;
            status_o         <= ST_DONE;
            removed_count_o  <= '0;
            best_bid_o       <= '0;
            best_bid_valid_o <= 1'b0;
            best_ask_o       <= '0;
            best_ask_valid_o <= 1'b0;
            last_o           <= 1'b0;
            state_q          <= S_OUT;
          end else begin
            state_q <= S_PRE;
          end
        end
        S_OUT: begin
          wr_q <= '0;
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q     <= done_q ? S_IDLE : S_PRE;
          end
        end
        default: begin
          wr_q    <= '0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // no storage write may land while a pass is reading the table
  a_no_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !(wr_q.all || wr_q.size || wr_q.arr))
    else $error("slot write during scan");

  // a transferred status record ends the operation
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (state_q == S_IDLE))
    else $error("operation did not end after status");

  // trade records never carry status-only fields
  a_trade_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == RK_TRADE)) |->
      (!last_o && (removed_count_o == '0) && !best_bid_valid_o && !best_ask_valid_o))
    else $error("trade record with status fields");

  // output only presented from the output state
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OUT))
    else $error("result outside output state");

endmodule
